// ----- hw/rtl/ctsc_pkg.sv -----
package ctsc_pkg;

	localparam logic [4:0] HOUR_TOP   = 5'd23;
	localparam logic [5:0] MINUTE_TOP = 6'd59;
	localparam logic [3:0] DIGIT_BLANK = 4'd10;

	typedef enum logic [2:0] {
		OP_READ = 3'd0,
		OP_MODE = 3'd1,
		OP_SAVE = 3'd2,
		OP_UP   = 3'd3,
		OP_DOWN = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_VIEW   = 2'd0,
		MODE_HOUR   = 2'd1,
		MODE_MINUTE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [4:0] clock_hour;
		logic [5:0] clock_minute;
		logic [5:0] clock_second;
		logic       blink_off;
	} in_item_t;

	typedef struct packed {
		logic [3:0] digit_hour_tens;
		logic [3:0] digit_hour_ones;
		logic [3:0] digit_minute_tens;
		logic [3:0] digit_minute_ones;
		logic [3:0] digit_second_tens;
		logic [3:0] digit_second_ones;
		logic       write_strobe;
		logic [4:0] write_hour;
		logic [5:0] write_minute;
		logic [5:0] write_second;
		logic [1:0] current_mode;
	} out_item_t;

	// state after the item, as seen by the display formatter
	typedef struct packed {
		mode_t      mode;
		logic       blink_off;
		logic [4:0] edit_hour;
		logic [5:0] edit_minute;
		logic [4:0] seen_hour;
		logic [5:0] seen_minute;
		logic [5:0] seen_second;
	} disp_view_t;

	typedef struct packed {
		logic       write_strobe;
		logic [4:0] write_hour;
		logic [5:0] write_minute;
		logic [5:0] write_second;
	} wr_cmd_t;

	// tens of a 6-bit value: v*205 >> 11 is exact for v < 1029
	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [13:0] prod;
		prod = {8'd0, v} * 14'd205;
		return {1'b0, prod[13:11]};
	endfunction

	function automatic logic [3:0] ones_of(input logic [5:0] v);
		logic [3:0] t;
		logic [6:0] tx10;
		logic [6:0] diff;
		t = tens_of(v);
		tx10 = {3'd0, t} * 7'd10;
		diff = {1'b0, v} - tx10;
		return diff[3:0];
	endfunction

endpackage

// ----- hw/rtl/ctsc_ctrl.sv -----
module ctsc_ctrl
	import ctsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  in_item_t   item,
	output disp_view_t view,
	output wr_cmd_t    wr
);

	mode_t      mode_q, mode_d;
	logic [4:0] edit_hour_q, edit_hour_d;
	logic [5:0] edit_minute_q, edit_minute_d;
	logic       edited_q, edited_d;
	logic [4:0] seen_hour_q, seen_hour_d;
	logic [5:0] seen_minute_q, seen_minute_d;
	logic [5:0] seen_second_q, seen_second_d;
	logic       strobe;
	logic       is_up;

	assign is_up = (item.operation == OP_UP);

	// next mode
	always_comb begin
		mode_d = mode_q;
		case (item.operation)
			OP_MODE: begin
				case (mode_q)
					MODE_VIEW:   mode_d = MODE_HOUR;
					MODE_HOUR:   mode_d = MODE_MINUTE;
					MODE_MINUTE: mode_d = MODE_VIEW;
					default:     mode_d = mode_q;
				endcase
			end
			OP_SAVE: begin
				if (mode_q != MODE_VIEW) begin
					mode_d = MODE_VIEW;
				end
			end
			default: mode_d = mode_q;
		endcase
	end

	// datapath and strobe
	always_comb begin
		edit_hour_d   = edit_hour_q;
		edit_minute_d = edit_minute_q;
		edited_d      = edited_q;
		seen_hour_d   = seen_hour_q;
		seen_minute_d = seen_minute_q;
		seen_second_d = seen_second_q;
		strobe        = 1'b0;
		case (item.operation)
			OP_READ: begin
				seen_hour_d   = item.clock_hour;
				seen_minute_d = item.clock_minute;
				seen_second_d = item.clock_second;
			end
			OP_MODE: begin
				if (mode_q == MODE_VIEW) begin
					edit_hour_d   = seen_hour_q;
					edit_minute_d = seen_minute_q;
					edited_d      = 1'b0;
				end else if (mode_q == MODE_MINUTE) begin
					strobe = 1'b1;
				end
			end
			OP_SAVE: begin
				strobe = (mode_q != MODE_VIEW);
			end
			OP_UP, OP_DOWN: begin
				if (mode_q == MODE_HOUR) begin
					if (is_up) begin
						edit_hour_d = (edit_hour_q >= HOUR_TOP) ? 5'd0 : edit_hour_q + 5'd1;
					end else begin
						edit_hour_d = (edit_hour_q == 5'd0) ? HOUR_TOP : edit_hour_q - 5'd1;
					end
					edited_d = 1'b1;
				end else if (mode_q == MODE_MINUTE) begin
					if (is_up) begin
						edit_minute_d = (edit_minute_q >= MINUTE_TOP) ? 6'd0
							: edit_minute_q + 6'd1;
					end else begin
						edit_minute_d = (edit_minute_q == 6'd0) ? MINUTE_TOP
							: edit_minute_q - 6'd1;
					end
					edited_d = 1'b1;
				end
			end
			default: strobe = 1'b0;
		endcase
	end

	// outputs
	always_comb begin
		view.mode        = mode_d;
		view.blink_off   = item.blink_off;
		view.edit_hour   = edit_hour_d;
		view.edit_minute = edit_minute_d;
		view.seen_hour   = seen_hour_d;
		view.seen_minute = seen_minute_d;
		view.seen_second = seen_second_d;
		wr.write_strobe  = strobe;
		wr.write_hour    = strobe ? edit_hour_d : 5'd0;
		wr.write_minute  = strobe ? edit_minute_d : 6'd0;
		wr.write_second  = (strobe && !edited_d) ? item.clock_second : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_VIEW;
			edit_hour_q   <= '0;
			edit_minute_q <= '0;
			edited_q      <= 1'b0;
			seen_hour_q   <= '0;
			seen_minute_q <= '0;
			seen_second_q <= '0;
		end else if (advance) begin
			mode_q        <= mode_d;
			edit_hour_q   <= edit_hour_d;
			edit_minute_q <= edit_minute_d;
			edited_q      <= edited_d;
			seen_hour_q   <= seen_hour_d;
			seen_minute_q <= seen_minute_d;
			seen_second_q <= seen_second_d;
		end
	end

endmodule

// ----- hw/rtl/ctsc_disp.sv -----
module ctsc_disp
	import ctsc_pkg::*;
(
	input  disp_view_t view,
	input  wr_cmd_t    wr,
	output out_item_t  result
);

	logic [5:0] hour_val;
	logic [5:0] min_val;
	logic       hour_blank;
	logic       min_blank;
	logic       set_mode;

	assign set_mode   = (view.mode != MODE_VIEW);
	assign hour_val   = set_mode ? {1'b0, view.edit_hour} : {1'b0, view.seen_hour};
	assign min_val    = set_mode ? view.edit_minute : view.seen_minute;
	assign hour_blank = (view.mode == MODE_HOUR) && view.blink_off;
	assign min_blank  = (view.mode == MODE_MINUTE) && view.blink_off;

	always_comb begin
		result.digit_hour_tens   = hour_blank ? DIGIT_BLANK : tens_of(hour_val);
		result.digit_hour_ones   = hour_blank ? DIGIT_BLANK : ones_of(hour_val);
		result.digit_minute_tens = min_blank ? DIGIT_BLANK : tens_of(min_val);
		result.digit_minute_ones = min_blank ? DIGIT_BLANK : ones_of(min_val);
		result.digit_second_tens = set_mode ? DIGIT_BLANK : tens_of(view.seen_second);
		result.digit_second_ones = set_mode ? DIGIT_BLANK : ones_of(view.seen_second);
		result.write_strobe      = wr.write_strobe;
		result.write_hour        = wr.write_hour;
		result.write_minute      = wr.write_minute;
		result.write_second      = wr.write_second;
		result.current_mode      = view.mode;
	end

endmodule

// ----- hw/rtl/clock_time_set_controller.sv -----
// Clock time set controller.
// Input channel (item_valid/item_ready/item): one event per transfer, a clock
// reading or a debounced mode, save, up or down press, with the current clock
// time and the blink phase. Output channel (result_valid/result_ready/result):
// one result per event with six display digit codes (10 = blank), the clock
// write command and the mode after the event.
// Path: an item is registered in the input register, and its result in the
// result register, which drives result_valid. Throughput: one item per cycle
// while the receiver takes results; the mode/edit state is updated as an item
// moves from the input register to the result register, so the next item sees
// it without a bubble.
// A stalled receiver holds the result register; one more item then waits in
// the input register and item_ready drops until the result is taken.
// Reset puts the block in view mode with all times zero and both registers
// empty.
module clock_time_set_controller
	import ctsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	in_item_t   item_s1;
	logic       valid_s1;
	logic       advance;
	out_item_t  result_q;
	logic       result_valid_q;
	out_item_t  result_d;
	disp_view_t view;
	wr_cmd_t    wr;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	ctsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.view    (view),
		.wr      (wr)
	);

	ctsc_disp u_disp (
		.view   (view),
		.wr     (wr),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_strobe_in_view: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_strobe |-> result.current_mode == MODE_VIEW)
		else $error("write strobe outside view mode");

	a_no_strobe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.write_strobe |->
			result.write_hour == 5'd0 && result.write_minute == 6'd0
			&& result.write_second == 6'd0)
		else $error("write fields nonzero without strobe");

	a_view_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.current_mode == MODE_VIEW |->
			result.digit_second_tens != DIGIT_BLANK
			&& result.digit_second_ones != DIGIT_BLANK)
		else $error("seconds blank in view mode");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a pending item");
`endif

endmodule
